### design/sfr_pkg.sv
`timescale 1ns / 1ps

package sfr_pkg;

  // default sizes for the pattern stores
  localparam int MAX_FIND_BYTES    = 8;
  localparam int MAX_REPLACE_BYTES = 8;

  // upper bound of both pattern sizes, sets the job payload
  localparam int JOB_BYTES = 8;
  localparam int JOB_IDX_W = $clog2(JOB_BYTES);

  // byte counts 0..8
  localparam int CNT_W = 4;

  // configuration port
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;

  // depth of the job queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIND_PAT = 2'd0,
    CFG_FIND_LEN = 2'd1,
    CFG_REPL_PAT = 2'd2,
    CFG_REPL_LEN = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_present;
    logic       out_last;
  } out_t;

  // one step's results: cnt bytes from bytes[0] upward
  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] bytes;
    logic [CNT_W-1:0]          cnt;
    logic                      present;
    logic                      last;
  } job_t;

endpackage

### design/sfr_front.sv
`timescale 1ns / 1ps

module sfr_front #(
  parameter int MAX_FIND_BYTES    = sfr_pkg::MAX_FIND_BYTES,
  parameter int MAX_REPLACE_BYTES = sfr_pkg::MAX_REPLACE_BYTES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfr_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_push,
  input  sfr_pkg::in_t                  in_data,
  output logic                          in_full,
  input  logic                          q_full,
  output logic                          job_push,
  output sfr_pkg::job_t                 job
);

  localparam int CNT_W  = sfr_pkg::CNT_W;
  localparam int FW     = MAX_FIND_BYTES * 8;
  localparam int RW     = MAX_REPLACE_BYTES * 8;
  localparam int JW     = sfr_pkg::JOB_BYTES * 8;
  localparam int FILL_W = (MAX_FIND_BYTES > 1) ? $clog2(MAX_FIND_BYTES) : 1;

  logic [FW-1:0]     find_pat_r;
  logic [CNT_W-1:0]  find_len_r;
  logic [RW-1:0]     repl_pat_r;
  logic [CNT_W-1:0]  repl_len_r;
  logic [FW-1:0]     win_r, win_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  logic                      accept;
  logic [FW-1:0]             wn;
  logic [MAX_FIND_BYTES-1:0] hit;
  logic [CNT_W-1:0]          flen, rlen, n, p;
  logic                      last, match;

  assign accept  = in_push && !q_full;
  assign in_full = q_full;
  assign last    = in_data.end_of_string;

  // saturated pattern lengths
  assign flen = (find_len_r > CNT_W'(MAX_FIND_BYTES)) ? CNT_W'(MAX_FIND_BYTES) : find_len_r;
  assign rlen = (repl_len_r > CNT_W'(MAX_REPLACE_BYTES)) ?
                CNT_W'(MAX_REPLACE_BYTES) : repl_len_r;
  assign n    = CNT_W'(fill_r) + CNT_W'(1);

  // window with the new byte appended, compared in parallel with the pattern
  always_comb begin
    wn  = win_r;
    hit = '0;
    for (int i = 0; i < MAX_FIND_BYTES; i++) begin
      if (FILL_W'(i) == fill_r) begin
        wn[i*8 +: 8] = in_data.data_byte;
      end
      hit[i] = (wn[i*8 +: 8] == find_pat_r[i*8 +: 8]) || (CNT_W'(i) >= flen);
    end
  end

  assign match = (flen != '0) && (n == flen) && (&hit);

  // number of oldest bytes released this step
  always_comb begin
    if (match) begin
      p = '0;
    end else if (flen == '0 || last) begin
      p = n;
    end else if (n >= flen) begin
      p = n - flen + CNT_W'(1);
    end else begin
      p = '0;
    end
  end

  // window update
  always_comb begin
    win_nxt  = wn >> {p, 3'b000};
    fill_nxt = FILL_W'(n - p);
    if (match || last) begin
      win_nxt  = '0;
      fill_nxt = '0;
    end
  end

  // job for the back end
  always_comb begin
    job.last = last;
    if (match) begin
      job_push    = accept && (rlen != '0 || last);
      job.cnt     = (rlen == '0) ? CNT_W'(1) : rlen;
      job.present = (rlen != '0);
      job.bytes   = (rlen == '0) ? '0 : JW'(repl_pat_r);
    end else begin
      job_push    = accept && (p != '0);
      job.cnt     = p;
      job.present = 1'b1;
      job.bytes   = JW'(wn);
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      find_pat_r <= '0;
      find_len_r <= '0;
      repl_pat_r <= '0;
      repl_len_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sfr_pkg::CFG_FIND_PAT: find_pat_r <= cfg_wdata[FW-1:0];
        sfr_pkg::CFG_FIND_LEN: find_len_r <= cfg_wdata[CNT_W-1:0];
        sfr_pkg::CFG_REPL_PAT: repl_pat_r <= cfg_wdata[RW-1:0];
        sfr_pkg::CFG_REPL_LEN: repl_len_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= '0;
      fill_r <= '0;
    end else if (accept) begin
      win_r  <= win_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule

### design/sfr_fifo.sv
`timescale 1ns / 1ps

module sfr_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sfr_pkg::job_t wr_job,
  output logic          full,
  input  logic          pop,
  output sfr_pkg::job_t rd_job,
  output logic          empty
);

  localparam int DEPTH = sfr_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sfr_pkg::job_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_job  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

endmodule

### design/sfr_back.sv
`timescale 1ns / 1ps

module sfr_back (
  input  logic          clk,
  input  logic          rst_n,
  input  sfr_pkg::job_t q_job,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          out_empty,
  input  logic          out_pop,
  output sfr_pkg::out_t out_data
);

  localparam int CNT_W = sfr_pkg::CNT_W;
  localparam int IDX_W = sfr_pkg::JOB_IDX_W;

  sfr_pkg::job_t    cur_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             busy_r, busy_nxt;
  logic             take, last_beat, load;

  assign take      = out_pop && busy_r;
  assign last_beat = (CNT_W'(idx_r) + CNT_W'(1)) == cur_r.cnt;
  assign load      = !busy_r || (take && last_beat);
  assign q_pop     = load && !q_empty;

  // result ports straight from the current job
  assign out_empty             = !busy_r;
  assign out_data.out_byte     = cur_r.bytes[idx_r];
  assign out_data.byte_present = cur_r.present;
  assign out_data.out_last     = cur_r.last && last_beat;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (load) begin
      busy_nxt = !q_empty;
      idx_nxt  = '0;
    end else if (take) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

endmodule

### design/stream_find_replace_top.sv
`timescale 1ns / 1ps

// channel  | ports                          | transfer when
// ---------+--------------------------------+------------------------
// input    | in_push, in_full, in_data      | in_push & !in_full
// result   | out_pop, out_empty, out_data   | out_pop & !out_empty
// config   | cfg_we, cfg_index, cfg_wdata   | cfg_we
//
// the front takes one byte per cycle unless full; window compare is combinational
// the back issues one result per cycle while popped, so a step with k results
// holds it until all k are taken; a replacement longer than one byte stalls input
// through the two-entry queue; results pass it, then the back's job register
// rst_n is synchronous; no clearing pass, ready as soon as reset is released

module stream_find_replace_top #(
  parameter int MAX_FIND_BYTES    = sfr_pkg::MAX_FIND_BYTES,
  parameter int MAX_REPLACE_BYTES = sfr_pkg::MAX_REPLACE_BYTES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfr_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_push,
  input  sfr_pkg::in_t                  in_data,
  output logic                          in_full,
  output logic                          out_empty,
  input  logic                          out_pop,
  output sfr_pkg::out_t                 out_data
);

  sfr_pkg::job_t f_job, q_job;
  logic          f_push, q_full, q_pop, q_empty;

  sfr_front #(
    .MAX_FIND_BYTES    (MAX_FIND_BYTES),
    .MAX_REPLACE_BYTES (MAX_REPLACE_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .q_full    (q_full),
    .job_push  (f_push),
    .job       (f_job)
  );

  sfr_fifo u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (f_push),
    .wr_job (f_job),
    .full   (q_full),
    .pop    (q_pop),
    .rd_job (q_job),
    .empty  (q_empty)
  );

  sfr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_job     (q_job),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

### design/sfr_checker.sv
`timescale 1ns / 1ps

module sfr_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_push,
  input logic          in_full,
  input sfr_pkg::in_t  in_data,
  input logic          out_empty,
  input logic          out_pop,
  input sfr_pkg::out_t out_data
);

  // nothing waits and input is open right after reset
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("result or full flag set after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_data))
    else $error("waiting result changed");

  // end of string always yields a waiting result
  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_push && !in_full && in_data.end_of_string |-> ##2 !out_empty)
    else $error("no result after end of string");

  // a marker without a byte is only the final result
  a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_data.byte_present |-> out_data.out_last)
    else $error("marker result not last");

endmodule

bind stream_find_replace_top sfr_checker u_chk (.*);

### test/tb_stream_find_replace_top.sv
`timescale 1ns / 1ps

module tb_stream_find_replace_top;
  import sfr_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int NUM_ITEMS   = 470;
  localparam int QUIET_FROM  = 410;
  localparam int SETTLE      = 8;

  // tracks the rewritten stream the block should produce
  class rewrite_tracker;
    logic [63:0] find_pat;
    logic [3:0]  find_len;
    logic [63:0] repl_pat;
    logic [3:0]  repl_len;
    logic [7:0]  window [MAX_FIND_BYTES];
    int          fill;
    int          step_results;
    out_t        rewritten_q[$];
    int          fails;

    function new();
      find_pat = '0;
      find_len = '0;
      repl_pat = '0;
      repl_len = '0;
      clear_window();
      fails = 0;
    endfunction

    function void clear_window();
      for (int i = 0; i < MAX_FIND_BYTES; i++) window[i] = 8'h00;
      fill = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [63:0] value);
      case (idx)
        CFG_FIND_PAT: find_pat = value;
        CFG_FIND_LEN: find_len = value[3:0];
        CFG_REPL_PAT: repl_pat = value;
        CFG_REPL_LEN: repl_len = value[3:0];
        default: ;
      endcase
    endfunction

    function void add_result(logic [7:0] b, logic present);
      out_t r;
      if (step_results >= 8) return;
      r.out_byte     = b;
      r.byte_present = present;
      r.out_last     = 1'b0;
      rewritten_q.push_back(r);
      step_results++;
    endfunction

    // emit the oldest pending byte unchanged
    function void emit_oldest();
      logic [7:0] b;
      if (fill == 0) return;
      b = window[0];
      for (int i = 0; i < MAX_FIND_BYTES - 1; i++) window[i] = window[i+1];
      window[MAX_FIND_BYTES-1] = 8'h00;
      fill--;
      add_result(b, 1'b1);
    endfunction

    function bit window_hit(int flen);
      for (int i = 0; i < flen; i++) begin
        if (window[i] != find_pat[8*i +: 8]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_byte(in_t item);
      int   flen;
      int   rlen;
      out_t tail;
      flen = (find_len > MAX_FIND_BYTES) ? MAX_FIND_BYTES : int'(find_len);
      rlen = (repl_len > MAX_REPLACE_BYTES) ? MAX_REPLACE_BYTES : int'(repl_len);
      step_results = 0;
      if (fill < MAX_FIND_BYTES) begin
        window[fill] = item.data_byte;
        fill++;
      end else begin
        add_result(item.data_byte, 1'b1);
      end
      // zero length passes through, lowered length flushes without a compare
      if (flen == 0) begin
        while (fill > 0) emit_oldest();
      end else if (fill > flen) begin
        while (fill >= flen) emit_oldest();
      end else if (fill == flen) begin
        if (window_hit(flen)) begin
          for (int i = 0; i < rlen; i++) add_result(repl_pat[8*i +: 8], 1'b1);
          clear_window();
        end else begin
          emit_oldest();
        end
      end
      // string end: flush, marker if nothing came out, tag the final result
      if (item.end_of_string) begin
        while (fill > 0) emit_oldest();
        if (step_results == 0) add_result(8'h00, 1'b0);
        tail = rewritten_q.pop_back();
        tail.out_last = 1'b1;
        rewritten_q.push_back(tail);
        clear_window();
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (rewritten_q.size() == 0) begin
        $error("unexpected result: out_byte %0h byte_present %0b out_last %0b",
               got.out_byte, got.byte_present, got.out_last);
        fails++;
        return;
      end
      want = rewritten_q.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %0h, actual %0h", want.out_byte, got.out_byte);
        fails++;
      end
      if (got.byte_present !== want.byte_present) begin
        $error("byte_present: expected %0b, actual %0b", want.byte_present,
               got.byte_present);
        fails++;
      end
      if (got.out_last !== want.out_last) begin
        $error("out_last: expected %0b, actual %0b", want.out_last, got.out_last);
        fails++;
      end
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_push   = 1'b0;
  in_t                  in_data   = '0;
  logic                 in_full;
  logic                 out_empty;
  logic                 out_pop   = 1'b0;
  out_t                 out_data;

  rewrite_tracker tracker = new();
  bit             idle_on = 1'b1;
  int             item_count = 0;
  int             stall_cycles = 0;

  stream_find_replace_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: pop with random stall bursts
  initial begin
    do @(posedge clk); while (!rst_n);
    forever begin
      if (idle_on && $urandom_range(0, 4) == 0) begin
        out_pop <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      if (!out_empty) tracker.check_result(out_data);
    end
  end

  // one input transfer, with an optional gap ahead of it
  task automatic push_byte(logic [7:0] b, logic last);
    in_t item;
    item.data_byte     = b;
    item.end_of_string = last;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_full);
    tracker.note_byte(item);
    item_count++;
  endtask

  // stop sending and let every expected result drain out
  task automatic drain();
    in_push <= 1'b0;
    while (tracker.rewritten_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    tracker.write_reg(idx, value);
  endtask

  task automatic set_config(logic [63:0] fp, logic [63:0] fl, logic [63:0] rp,
                            logic [63:0] rl);
    write_reg(CFG_FIND_PAT, fp);
    write_reg(CFG_FIND_LEN, fl);
    write_reg(CFG_REPL_PAT, rp);
    write_reg(CFG_REPL_LEN, rl);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] rand_pattern();
    logic [63:0] p;
    p = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: p = '0;
      1: p = '1;
      // tiny alphabet gives plenty of partial and overlapping matches
      2, 3: begin
        for (int i = 0; i < 8; i++) begin
          case ($urandom_range(0, 2))
            0: p[8*i +: 8] = 8'h61;
            1: p[8*i +: 8] = 8'h62;
            default: p[8*i +: 8] = 8'h00;
          endcase
        end
      end
      default: ;
    endcase
    return p;
  endfunction

  function automatic logic [63:0] rand_len();
    logic [63:0] upper;
    int          l;
    case ($urandom_range(0, 9))
      0: l = 0;
      1: l = $urandom_range(9, 15);
      2: l = 8;
      default: l = $urandom_range(1, 8);
    endcase
    upper = $urandom_range(0, 1) ? {$urandom, $urandom} : 64'h0;
    return {upper[63:4], l[3:0]};
  endfunction

  function automatic logic [7:0] pick_byte();
    int idx;
    idx = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return tracker.find_pat[8*idx +: 8];
  endfunction

  // stimulus
  initial begin
    logic [7:0] str_q[$];
    bit         noise;
    bit         open_end;
    int         target;
    int         flen;
    int         n;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config: zero find length passes bytes through
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);

    // leftmost match with an expanding replacement
    drain();
    set_config(64'h6261, 64'd2, 64'h7A7978, 64'd3);
    push_byte(8'h61, 1'b0);
    push_byte(8'h62, 1'b0);
    push_byte(8'h61, 1'b0);
    push_byte(8'h61, 1'b0);
    push_byte(8'h62, 1'b1);

    // deleted match on the final byte leaves only the end marker
    drain();
    set_config(64'h5A, 64'd1, 64'h0, 64'd0);
    push_byte(8'h5A, 1'b1);
    push_byte(8'h71, 1'b0);
    push_byte(8'h5A, 1'b1);

    // lengths above eight saturate
    drain();
    set_config('1, 64'd15, 64'h0, 64'd15);
    repeat (8) push_byte(8'hFF, 1'b0);
    push_byte(8'h7F, 1'b1);

    // find length lowered while bytes are pending
    drain();
    set_config(64'h11223344, 64'd4, 64'hEE, 64'd1);
    push_byte(8'h44, 1'b0);
    push_byte(8'h33, 1'b0);
    push_byte(8'h22, 1'b0);
    drain();
    write_reg(CFG_FIND_LEN, 64'd2);
    cfg_we <= 1'b0;
    push_byte(8'h33, 1'b0);
    push_byte(8'h44, 1'b1);

    // random phases, each with its own setting
    while (item_count < NUM_ITEMS) begin
      drain();
      if ($urandom_range(0, 4) == 0) begin
        write_reg(CFG_FIND_LEN, rand_len());
        cfg_we <= 1'b0;
      end else begin
        set_config(rand_pattern(), rand_len(), rand_pattern(), rand_len());
      end
      idle_on = (item_count < QUIET_FROM);
      target  = item_count + $urandom_range(15, 45);
      while (item_count < target) begin
        noise = ($urandom_range(0, 4) == 0);
        flen  = (tracker.find_len > 8) ? 8 : int'(tracker.find_len);
        str_q.delete();
        n = $urandom_range(1, 16);
        while (str_q.size() < n) begin
          if (!noise && $urandom_range(0, 2) == 0) begin
            // a full copy of the pattern mostly, a prefix at times
            if (flen == 0 || $urandom_range(0, 3) == 0) begin
              n = $urandom_range(1, 8);
            end else begin
              n = flen;
            end
            for (int j = 0; j < n; j++) str_q.push_back(tracker.find_pat[8*j +: 8]);
            n = str_q.size() + $urandom_range(0, 4);
          end else begin
            str_q.push_back(noise ? 8'($urandom_range(0, 255)) : pick_byte());
          end
        end
        open_end = (item_count + str_q.size() >= target) && ($urandom_range(0, 2) == 0);
        for (int j = 0; j < str_q.size(); j++) begin
          if (noise) begin
            push_byte(str_q[j], $urandom_range(0, 7) == 0);
          end else begin
            push_byte(str_q[j], (j == str_q.size() - 1) && !open_end);
          end
        end
      end
    end

    drain();
    if (tracker.fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
design/sfr_pkg.sv
design/sfr_front.sv
design/sfr_fifo.sv
design/sfr_back.sv
design/stream_find_replace_top.sv
design/sfr_checker.sv
test/tb_stream_find_replace_top.sv
